>>> hw/rtl/dca_pkg.sv
// Shared types and codes for the drive command arbiter.
package dca_pkg;

    // Item codes on the command field.
    localparam logic [2:0] CMD_NAV_WR    = 3'd0;
    localparam logic [2:0] CMD_DOCK_WR   = 3'd1;
    localparam logic [2:0] CMD_TELEOP_WR = 3'd2;
    localparam logic [2:0] CMD_SELECT    = 3'd3;
    localparam logic [2:0] CMD_SET_STOP  = 3'd4;

    // Slot numbers, equal to the low bits of the matching write command.
    localparam logic [1:0] SLOT_NAV    = 2'd0;
    localparam logic [1:0] SLOT_DOCK   = 2'd1;
    localparam logic [1:0] SLOT_TELEOP = 2'd2;
    localparam int unsigned NUM_SLOTS  = 3;

    // Source codes reported with each result.
    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_NAV    = 2'd1;
    localparam logic [1:0] SRC_DOCK   = 2'd2;
    localparam logic [1:0] SRC_TELEOP = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NAV_TIMEOUT    = 3'd0;
    localparam logic [2:0] CFG_DOCK_TIMEOUT   = 3'd1;
    localparam logic [2:0] CFG_TELEOP_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_MAX_LINEAR     = 3'd3;
    localparam logic [2:0] CFG_MAX_ANGULAR    = 3'd4;
    localparam logic [2:0] CFG_LINEAR_ACCEL   = 3'd5;
    localparam logic [2:0] CFG_ANGULAR_ACCEL  = 3'd6;
    localparam logic [2:0] CFG_NAV_FIRST      = 3'd7;

    // Configuration reset values.
    localparam logic [15:0] RST_TIMEOUT       = 16'd500;
    localparam logic [14:0] RST_MAX_LINEAR    = 15'd500;
    localparam logic [14:0] RST_MAX_ANGULAR   = 15'd1000;
    localparam logic [15:0] RST_LINEAR_ACCEL  = 16'd256;
    localparam logic [15:0] RST_ANGULAR_ACCEL = 16'd512;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] linear_vel;
        logic signed [15:0] angular_vel;
        logic [31:0]        time_now;
        logic [15:0]        elapsed_ms;
        logic               stop_flag;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] linear_out;
        logic signed [15:0] angular_out;
        logic [1:0]         source;
        logic               clamped;
    } t_out_item;

endpackage

>>> hw/rtl/dca_limit.sv
// Speed clamp followed by slew limiting for one velocity axis.
module dca_limit (
    input  logic signed [15:0] i_want,
    input  logic [14:0]        i_max,
    input  logic signed [15:0] i_prev,
    input  logic [15:0]        i_accel,
    input  logic [15:0]        i_dt,
    output logic signed [15:0] o_val,
    output logic               o_clamped
);

    logic signed [15:0] w_lim;
    logic signed [15:0] w_nlim;
    logic signed [15:0] w_clip;
    logic               w_speed_hit;
    logic [31:0]        w_prod;
    logic signed [24:0] w_step;
    logic signed [24:0] w_diff;
    logic signed [24:0] w_delta;
    logic signed [24:0] w_sum;
    logic               w_slew_hit;

    assign w_lim  = $signed({1'b0, i_max});
    assign w_nlim = -w_lim;

    always_comb begin
        w_clip      = i_want;
        w_speed_hit = 1'b0;
        if (i_want > w_lim) begin
            w_clip      = w_lim;
            w_speed_hit = 1'b1;
        end else if (i_want < w_nlim) begin
            w_clip      = w_nlim;
            w_speed_hit = 1'b1;
        end
    end

    // Allowed change is accel * dt in Q8.8, truncated to whole units.
    assign w_prod = 32'(i_accel) * 32'(i_dt);
    assign w_step = $signed({1'b0, w_prod[31:8]});
    assign w_diff = 25'(w_clip) - 25'(i_prev);

    always_comb begin
        w_delta    = w_diff;
        w_slew_hit = 1'b0;
        if (i_dt != 16'd0) begin
            if (w_diff > w_step) begin
                w_delta    = w_step;
                w_slew_hit = 1'b1;
            end else if (w_diff < -w_step) begin
                w_delta    = -w_step;
                w_slew_hit = 1'b1;
            end
        end
    end

    // The result always lies between the previous output and the clamped
    // request, so it fits the output width.
    assign w_sum     = 25'(i_prev) + w_delta;
    assign o_val     = w_sum[15:0];
    assign o_clamped = w_speed_hit | w_slew_hit;

endmodule

>>> hw/rtl/drive_command_arbiter.sv
// Top level of the drive command arbiter: slots, source selection and result register.
//
// The block takes one transaction per cycle, unless stalled, on the input channel
// (i_in_valid / o_in_ready, payload i_in). Write transactions store a velocity
// command with its timestamp in the navigation, docking or teleop slot unless
// stopped; a set-stop transaction changes the stopped state and, on a real
// change, empties all slots and forgets the previous output. Only a select
// transaction yields a result transaction on the output channel (o_out_valid /
// i_out_ready, payload o_out): the highest-priority fresh source, clamped to the
// speed limits and slew-limited against the previous output.
// An accepted transaction is held in an input register and worked on there by
// one pass of compares, one 16 x 16 multiply per axis and a clamp; its result
// is then held in the output register. The sustained rate is one transaction per
// cycle while the receiver keeps up. When the receiver stalls, the output register
// holds its result and the input register holds the next transaction; input ready
// falls only when both are full and the held transaction is a select. Reset
// (synchronous, active low) empties both registers, invalidates all slots, clears
// the previous output and the stopped state, and returns the configuration
// registers to their defaults. Configuration is written on the plain write port,
// one register per cycle with the write enable high.
module drive_command_arbiter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dca_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dca_pkg::t_out_item   o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_nav_timeout;
    logic [15:0] r_dock_timeout;
    logic [15:0] r_teleop_timeout;
    logic [14:0] r_max_linear;
    logic [14:0] r_max_angular;
    logic [15:0] r_linear_accel;
    logic [15:0] r_angular_accel;
    logic        r_nav_first;

    // Command slots and the feedback state.
    logic signed [15:0] r_slot_lin [dca_pkg::NUM_SLOTS];
    logic signed [15:0] r_slot_ang [dca_pkg::NUM_SLOTS];
    logic [31:0]        r_slot_time [dca_pkg::NUM_SLOTS];
    logic [dca_pkg::NUM_SLOTS-1:0] r_slot_valid;
    logic signed [15:0] r_prev_lin;
    logic signed [15:0] r_prev_ang;
    logic               r_stopped;

    // Input register and result register.
    logic                r_in_valid;
    dca_pkg::t_in_item   r_in;
    logic                r_out_valid;
    dca_pkg::t_out_item  r_out;

    logic                w_is_write;
    logic                w_is_select;
    logic                w_is_stop;
    logic                w_out_free;
    logic                w_advance;
    logic [15:0]         w_timeout [dca_pkg::NUM_SLOTS];
    logic [dca_pkg::NUM_SLOTS-1:0] w_fresh;
    logic [31:0]         w_age [dca_pkg::NUM_SLOTS];
    logic [1:0]          w_src;
    logic [1:0]          w_idx;
    logic signed [15:0]  w_lin_val;
    logic signed [15:0]  w_ang_val;
    logic                w_lin_hit;
    logic                w_ang_hit;
    dca_pkg::t_out_item  n_out;

    // ------------------------------------------------------------------
    // Handshake. The input register moves on whenever its transaction
    // needs no result slot, or the result slot is free or being emptied.
    // ------------------------------------------------------------------
    assign w_is_write  = (r_in.cmd == dca_pkg::CMD_NAV_WR) ||
                         (r_in.cmd == dca_pkg::CMD_DOCK_WR) ||
                         (r_in.cmd == dca_pkg::CMD_TELEOP_WR);
    assign w_is_select = (r_in.cmd == dca_pkg::CMD_SELECT);
    assign w_is_stop   = (r_in.cmd == dca_pkg::CMD_SET_STOP);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_advance   = r_in_valid && (!w_is_select || w_out_free);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Freshness: written, not stamped in the future, and within timeout.
    // ------------------------------------------------------------------
    assign w_timeout[dca_pkg::SLOT_NAV]    = r_nav_timeout;
    assign w_timeout[dca_pkg::SLOT_DOCK]   = r_dock_timeout;
    assign w_timeout[dca_pkg::SLOT_TELEOP] = r_teleop_timeout;

    always_comb begin
        for (int i = 0; i < dca_pkg::NUM_SLOTS; i++) begin
            w_age[i]   = r_in.time_now - r_slot_time[i];
            w_fresh[i] = r_slot_valid[i] && (r_in.time_now >= r_slot_time[i]) &&
                         (w_age[i] <= 32'(w_timeout[i]));
        end
    end

    // Docking always wins; the priority register orders the other two.
    always_comb begin
        w_src = dca_pkg::SRC_NONE;
        w_idx = dca_pkg::SLOT_NAV;
        if (!r_stopped) begin
            if (w_fresh[dca_pkg::SLOT_DOCK]) begin
                w_src = dca_pkg::SRC_DOCK;
                w_idx = dca_pkg::SLOT_DOCK;
            end else if (r_nav_first) begin
                if (w_fresh[dca_pkg::SLOT_NAV]) begin
                    w_src = dca_pkg::SRC_NAV;
                    w_idx = dca_pkg::SLOT_NAV;
                end else if (w_fresh[dca_pkg::SLOT_TELEOP]) begin
                    w_src = dca_pkg::SRC_TELEOP;
                    w_idx = dca_pkg::SLOT_TELEOP;
                end
            end else begin
                if (w_fresh[dca_pkg::SLOT_TELEOP]) begin
                    w_src = dca_pkg::SRC_TELEOP;
                    w_idx = dca_pkg::SLOT_TELEOP;
                end else if (w_fresh[dca_pkg::SLOT_NAV]) begin
                    w_src = dca_pkg::SRC_NAV;
                    w_idx = dca_pkg::SLOT_NAV;
                end
            end
        end
    end

    dca_limit u_lin_limit (
        .i_want    (r_slot_lin[w_idx]),
        .i_max     (r_max_linear),
        .i_prev    (r_prev_lin),
        .i_accel   (r_linear_accel),
        .i_dt      (r_in.elapsed_ms),
        .o_val     (w_lin_val),
        .o_clamped (w_lin_hit)
    );

    dca_limit u_ang_limit (
        .i_want    (r_slot_ang[w_idx]),
        .i_max     (r_max_angular),
        .i_prev    (r_prev_ang),
        .i_accel   (r_angular_accel),
        .i_dt      (r_in.elapsed_ms),
        .o_val     (w_ang_val),
        .o_clamped (w_ang_hit)
    );

    // With no source the result is all zero, which also becomes the new
    // previous output.
    always_comb begin
        n_out = '0;
        if (w_src != dca_pkg::SRC_NONE) begin
            n_out.linear_out  = w_lin_val;
            n_out.angular_out = w_ang_val;
            n_out.source      = w_src;
            n_out.clamped     = w_lin_hit | w_ang_hit;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nav_timeout    <= dca_pkg::RST_TIMEOUT;
            r_dock_timeout   <= dca_pkg::RST_TIMEOUT;
            r_teleop_timeout <= dca_pkg::RST_TIMEOUT;
            r_max_linear     <= dca_pkg::RST_MAX_LINEAR;
            r_max_angular    <= dca_pkg::RST_MAX_ANGULAR;
            r_linear_accel   <= dca_pkg::RST_LINEAR_ACCEL;
            r_angular_accel  <= dca_pkg::RST_ANGULAR_ACCEL;
            r_nav_first      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dca_pkg::CFG_NAV_TIMEOUT:    r_nav_timeout    <= i_cfg_data;
                dca_pkg::CFG_DOCK_TIMEOUT:   r_dock_timeout   <= i_cfg_data;
                dca_pkg::CFG_TELEOP_TIMEOUT: r_teleop_timeout <= i_cfg_data;
                dca_pkg::CFG_MAX_LINEAR:     r_max_linear     <= i_cfg_data[14:0];
                dca_pkg::CFG_MAX_ANGULAR:    r_max_angular    <= i_cfg_data[14:0];
                dca_pkg::CFG_LINEAR_ACCEL:   r_linear_accel   <= i_cfg_data;
                dca_pkg::CFG_ANGULAR_ACCEL:  r_angular_accel  <= i_cfg_data;
                dca_pkg::CFG_NAV_FIRST:      r_nav_first      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // ------------------------------------------------------------------
    // Slot and feedback state, updated as each transaction leaves the
    // input register, so the next one in line sees its effect.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_prev_lin   <= '0;
            r_prev_ang   <= '0;
            r_stopped    <= 1'b0;
        end else if (w_advance) begin
            if (w_is_write && !r_stopped) begin
                r_slot_valid[r_in.cmd[1:0]] <= 1'b1;
            end
            if (w_is_stop && (r_in.stop_flag != r_stopped)) begin
                r_stopped    <= r_in.stop_flag;
                r_slot_valid <= '0;
                r_prev_lin   <= '0;
                r_prev_ang   <= '0;
            end
            if (w_is_select) begin
                r_prev_lin <= n_out.linear_out;
                r_prev_ang <= n_out.angular_out;
            end
        end
    end

    // Slot payload is only used while its valid bit is set.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_write && !r_stopped) begin
            r_slot_lin[r_in.cmd[1:0]]  <= r_in.linear_vel;
            r_slot_ang[r_in.cmd[1:0]]  <= r_in.angular_vel;
            r_slot_time[r_in.cmd[1:0]] <= r_in.time_now;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_select) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_select) begin
            r_out <= n_out;
        end
    end

endmodule
